FILE: design/rmfa_pkg.sv
// Shared constants, types and fixed-point helpers for the rotation matrix block.
package rmfa_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int WORK_BITS  = 30;
    localparam int OUT_W      = FRAC_BITS + 2;
    localparam int SAT_W      = OUT_W + 4;
    localparam int PROD_W     = 2 * OUT_W;
    localparam int R_W        = ANGLE_BITS - 1;
    localparam int X_W        = WORK_BITS + 1;
    localparam int X2_W       = WORK_BITS + 2;
    localparam int SIN_W      = FRAC_BITS + 1;
    localparam int RCP_W      = X2_W + 1;
    localparam int TAY_STEPS  = 7;
    // x register, x2 register, two stages per Taylor cell, rounding register
    localparam int SINE_LAT   = 2 + 2 * TAY_STEPS + 1;

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_SCALE = PI_Q60 >> 23;
    localparam logic [R_W-1:0] QUARTER = R_W'(1) << (ANGLE_BITS - 2);
    localparam logic [X_W-1:0] WORK_ONE = X_W'(1) << WORK_BITS;

    // floor(n / d) == (n * RCP) >> SHIFT for every n below 2^32
    localparam logic [RCP_W-1:0] TAY_RCP [TAY_STEPS] = '{
        RCP_W'(((72'd1 << 40) + 72'd209) / 72'd210),
        RCP_W'(((72'd1 << 40) + 72'd155) / 72'd156),
        RCP_W'(((72'd1 << 39) + 72'd109) / 72'd110),
        RCP_W'(((72'd1 << 39) + 72'd71)  / 72'd72),
        RCP_W'(((72'd1 << 38) + 72'd41)  / 72'd42),
        RCP_W'(((72'd1 << 37) + 72'd19)  / 72'd20),
        RCP_W'(((72'd1 << 35) + 72'd5)   / 72'd6)
    };
    localparam logic [5:0] TAY_SHIFT [TAY_STEPS] = '{
        6'd40, 6'd40, 6'd39, 6'd39, 6'd38, 6'd37, 6'd35
    };

    typedef struct packed {
        logic [X_W-1:0]  x;
        logic [X2_W-1:0] x2;
        logic [X_W-1:0]  t;
    } tay_t;

    // operand selectors for the matrix entries
    typedef logic [2:0] sel_t;
    localparam sel_t SEL_S1   = 3'd0;
    localparam sel_t SEL_C1   = 3'd1;
    localparam sel_t SEL_S2   = 3'd2;
    localparam sel_t SEL_C2   = 3'd3;
    localparam sel_t SEL_S3   = 3'd4;
    localparam sel_t SEL_C3   = 3'd5;
    localparam sel_t SEL_ONE  = 3'd6;
    localparam sel_t SEL_ZERO = 3'd7;

    localparam logic CONV_TILT  = 1'b0;
    localparam logic CONV_EULER = 1'b1;

    typedef struct packed {
        sel_t a1;
        sel_t a2;
        sel_t b1;
        sel_t b2;
        sel_t z;
        logic neg_a;
        logic neg_b;
    } op_t;

    typedef logic signed [OUT_W-1:0] fix_t;

    localparam logic signed [SAT_W-1:0] FIX_MAX = SAT_W'((1 << (FRAC_BITS + 1)) - 1);
    localparam logic signed [SAT_W-1:0] FIX_MIN = -SAT_W'(1 << (FRAC_BITS + 1));
    localparam logic signed [PROD_W:0]  FM_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    function automatic fix_t sat_fix(input logic signed [SAT_W-1:0] v);
        fix_t r;
        if (v > FIX_MAX) begin
            r = OUT_W'(FIX_MAX);
        end else if (v < FIX_MIN) begin
            r = OUT_W'(FIX_MIN);
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

    // rounded half up, saturated fixed-point product
    function automatic fix_t fmul(input fix_t a, input fix_t b);
        logic signed [PROD_W-1:0]         p;
        logic signed [PROD_W:0]           pr;
        logic signed [PROD_W-FRAC_BITS:0] q;
        p  = a * b;
        pr = {p[PROD_W-1], p} + FM_HALF;
        q  = pr[PROD_W:FRAC_BITS];
        return sat_fix(SAT_W'(q));
    endfunction

    function automatic op_t mk_op(input sel_t a1, input sel_t a2, input sel_t b1,
                                  input sel_t b2, input sel_t z, input logic na,
                                  input logic nb);
        op_t o;
        o.a1 = a1;
        o.a2 = a2;
        o.b1 = b1;
        o.b2 = b2;
        o.z  = z;
        o.neg_a = na;
        o.neg_b = nb;
        return o;
    endfunction

    // entry = sat(+-(A1*A2) +- (B1*B2)*Z)
    function automatic op_t op_entry(input logic conv, input logic [3:0] idx);
        op_t o;
        o = mk_op(SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
        if (conv == CONV_TILT) begin
            case (idx)
                4'd0: o = mk_op(SEL_C2, SEL_C3, SEL_S1, SEL_S2, SEL_S3, 1'b0, 1'b1);
                4'd1: o = mk_op(SEL_C2, SEL_S3, SEL_S1, SEL_S2, SEL_C3, 1'b0, 1'b0);
                4'd2: o = mk_op(SEL_C1, SEL_S2, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b1, 1'b0);
                4'd3: o = mk_op(SEL_C1, SEL_S3, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b1, 1'b0);
                4'd4: o = mk_op(SEL_C1, SEL_C3, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
                4'd5: o = mk_op(SEL_S1, SEL_ONE, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
                4'd6: o = mk_op(SEL_S2, SEL_C3, SEL_S1, SEL_C2, SEL_S3, 1'b0, 1'b0);
                4'd7: o = mk_op(SEL_S2, SEL_S3, SEL_S1, SEL_C2, SEL_C3, 1'b0, 1'b1);
                4'd8: o = mk_op(SEL_C1, SEL_C2, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
                default: o = mk_op(SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO,
                                   1'b0, 1'b0);
            endcase
        end else begin
            case (idx)
                4'd0: o = mk_op(SEL_C3, SEL_C1, SEL_C2, SEL_S3, SEL_S1, 1'b0, 1'b1);
                4'd1: o = mk_op(SEL_C3, SEL_S1, SEL_C2, SEL_S3, SEL_C1, 1'b0, 1'b0);
                4'd2: o = mk_op(SEL_S3, SEL_S2, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
                4'd3: o = mk_op(SEL_S3, SEL_C1, SEL_C2, SEL_C3, SEL_S1, 1'b1, 1'b1);
                4'd4: o = mk_op(SEL_S3, SEL_S1, SEL_C2, SEL_C3, SEL_C1, 1'b1, 1'b0);
                4'd5: o = mk_op(SEL_C3, SEL_S2, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
                4'd6: o = mk_op(SEL_S2, SEL_S1, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
                4'd7: o = mk_op(SEL_S2, SEL_C1, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b1, 1'b0);
                4'd8: o = mk_op(SEL_C2, SEL_ONE, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0);
                default: o = mk_op(SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO,
                                   1'b0, 1'b0);
            endcase
        end
        return o;
    endfunction

endpackage

FILE: design/rmfa_tay_cell.sv
// One Taylor step of the quarter-sine chain: t = 1 - (x2 * t) / d.
module rmfa_tay_cell
    import rmfa_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [RCP_W-1:0] rcp,
    input  logic [5:0]       rshift,
    input  tay_t             din,
    output tay_t             dout
);

    logic [X_W-1:0]  x_reg;
    logic [X2_W-1:0] x2_reg;
    logic [X2_W-1:0] n_reg;
    logic [X_W+X2_W-1:0] n_prod;
    logic [X2_W+RCP_W:0] q_prod;
    logic [X_W-1:0]  q_val;
    tay_t            dout_reg;

    assign n_prod = din.x2 * din.t;
    assign q_prod = (X2_W + RCP_W + 1)'(n_reg * rcp) >> rshift;
    assign q_val  = q_prod[X_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg  <= din.x;
            x2_reg <= din.x2;
            n_reg  <= n_prod[WORK_BITS +: X2_W];
            dout_reg.x  <= x_reg;
            dout_reg.x2 <= x2_reg;
            dout_reg.t  <= WORK_ONE - q_val;
        end
    end

    assign dout = dout_reg;

endmodule

FILE: design/rmfa_qsine.sv
// Quarter-wave sine: angle scaling, square, chain of Taylor cells, rounding.
module rmfa_qsine
    import rmfa_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [R_W-1:0]   r,
    output logic [SIN_W-1:0] sine
);

    logic [63:0]             x_prod;
    logic [X_W-1:0]          x_reg;
    logic [2*X_W-1:0]        sq_prod;
    tay_t                    head_reg;
    tay_t                    chain [TAY_STEPS+1];
    logic [2*X_W-1:0]        s_prod;
    logic [X2_W-1:0]         s_val;
    logic [X2_W-1:0]         s_clamp;
    logic [X2_W-1:0]         s_rnd;
    logic [SIN_W-1:0]        sine_reg;

    assign x_prod  = {{(64 - R_W){1'b0}}, r} * PI_SCALE;
    assign sq_prod = x_reg * x_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg       <= x_prod[ANGLE_BITS + 6 +: X_W];
            head_reg.x  <= x_reg;
            head_reg.x2 <= sq_prod[WORK_BITS +: X2_W];
            head_reg.t  <= WORK_ONE;
        end
    end

    assign chain[0] = head_reg;

    for (genvar g = 0; g < TAY_STEPS; g++) begin : g_cell
        rmfa_tay_cell u_cell (
            .aclk   (aclk),
            .en     (en),
            .rcp    (TAY_RCP[g]),
            .rshift (TAY_SHIFT[g]),
            .din    (chain[g]),
            .dout   (chain[g+1])
        );
    end

    assign s_prod  = chain[TAY_STEPS].x * chain[TAY_STEPS].t;
    assign s_val   = s_prod[WORK_BITS +: X2_W];
    assign s_clamp = (s_val > X2_W'(WORK_ONE)) ? X2_W'(WORK_ONE) : s_val;
    assign s_rnd   = s_clamp + (X2_W'(1) << (WORK_BITS - FRAC_BITS - 1));

    always_ff @(posedge aclk) begin
        if (en) begin
            sine_reg <= s_rnd[WORK_BITS - FRAC_BITS +: SIN_W];
        end
    end

    assign sine = sine_reg;

endmodule

FILE: design/rotation_matrix_from_angles.sv
// Top level: rotation matrix and determinant from three binary angles.
//
// Takes one word of three 16-bit binary angles (65536 units per turn) per cycle and returns
// the nine entries of the 3x3 rotation matrix and its saturated determinant, all signed
// Q2.16. Register convention picks the tilt form (0) or the z-x-z Euler form (1); write it
// only while no word is in flight. A new word can be taken every cycle; each word passes through
// the six quarter-sine pipelines (scaling, squaring, seven two-stage Taylor cells, rounding),
// one quadrant stage, three stages of matrix products and sums and three stages of determinant
// products and sum. The whole pipeline stalls only while a finished word waits at the output.
module rotation_matrix_from_angles
    import rmfa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_angle, second_angle, third_angle (16 bits each, from bit 0)
    input  logic [47:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r11, r12, r13, r21, r22, r23, r31, r32, r33, determinant (18 bits each), 4 zero bits
    output logic [183:0] m_tdata
);

    localparam int LAT = SINE_LAT + 7;
    localparam int QS  = SINE_LAT - 1;

    logic              conv_reg;
    logic              adv;
    logic [LAT-1:0]    vld_reg;

    // quadrant of each angle, carried alongside the sine pipelines
    logic [1:0]        quad_reg [3][SINE_LAT];
    logic [SIN_W-1:0]  sin_q [3];
    logic [SIN_W-1:0]  cos_q [3];
    logic [R_W-1:0]    sin_r [3];
    logic [R_W-1:0]    cos_r [3];

    fix_t              sc_reg [6];
    logic [7:0][OUT_W-1:0] sc_all;

    // matrix stages
    fix_t              pa_reg [9];
    fix_t              pb_reg [9];
    fix_t              z_reg  [9];
    logic              na_reg [9];
    logic              nb_reg [9];
    fix_t              pa2_reg [9];
    fix_t              fb_reg  [9];
    logic              na2_reg [9];
    logic              nb2_reg [9];
    fix_t              m_reg   [9];

    // determinant stages
    fix_t              md_reg [9];
    fix_t              me_reg [9];
    fix_t              mo_reg [9];
    fix_t              dp_reg [6];
    fix_t              dz_reg [6];
    fix_t              dt_reg [6];
    fix_t              det_reg;

    logic signed [SAT_W-1:0] det_sum;

    // Sarrus terms: first three add, last three subtract
    localparam logic [3:0] DA [6] = '{4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2};
    localparam logic [3:0] DB [6] = '{4'd4, 4'd5, 4'd3, 4'd5, 4'd3, 4'd4};
    localparam logic [3:0] DC [6] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6};

    // whole pipeline moves unless the output word is held
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_reg <= CONV_TILT;
            vld_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                conv_reg <= cfg_data;
            end
            if (adv) begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
        end
    end

    // sine and cosine pipelines
    for (genvar a = 0; a < 3; a++) begin : g_ang
        assign sin_r[a] = {1'b0, s_tdata[16*a +: ANGLE_BITS - 2]};
        assign cos_r[a] = QUARTER - sin_r[a];

        rmfa_qsine u_sin (
            .aclk (aclk),
            .en   (adv),
            .r    (sin_r[a]),
            .sine (sin_q[a])
        );

        rmfa_qsine u_cos (
            .aclk (aclk),
            .en   (adv),
            .r    (cos_r[a]),
            .sine (cos_q[a])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                quad_reg[a][0] <= s_tdata[16*a + ANGLE_BITS - 2 +: 2];
                for (int k = 1; k < SINE_LAT; k++) begin
                    quad_reg[a][k] <= quad_reg[a][k-1];
                end
            end
        end
    end

    // quadrant folding: signs and sine/cosine swap
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                case (quad_reg[a][QS])
                    2'd0: begin
                        sc_reg[2*a]   <= fix_t'({1'b0, sin_q[a]});
                        sc_reg[2*a+1] <= fix_t'({1'b0, cos_q[a]});
                    end
                    2'd1: begin
                        sc_reg[2*a]   <= fix_t'({1'b0, cos_q[a]});
                        sc_reg[2*a+1] <= -fix_t'({1'b0, sin_q[a]});
                    end
                    2'd2: begin
                        sc_reg[2*a]   <= -fix_t'({1'b0, sin_q[a]});
                        sc_reg[2*a+1] <= -fix_t'({1'b0, cos_q[a]});
                    end
                    default: begin
                        sc_reg[2*a]   <= -fix_t'({1'b0, cos_q[a]});
                        sc_reg[2*a+1] <= fix_t'({1'b0, sin_q[a]});
                    end
                endcase
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            sc_all[k] = sc_reg[k];
        end
        sc_all[SEL_ONE]  = OUT_W'(1) << FRAC_BITS;
        sc_all[SEL_ZERO] = '0;
    end

    // matrix: pair products, triple products, signed sums
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 9; i++) begin
                pa_reg[i] <= fmul(sc_all[op_entry(conv_reg, 4'(i)).a1],
                                  sc_all[op_entry(conv_reg, 4'(i)).a2]);
                pb_reg[i] <= fmul(sc_all[op_entry(conv_reg, 4'(i)).b1],
                                  sc_all[op_entry(conv_reg, 4'(i)).b2]);
                z_reg[i]  <= sc_all[op_entry(conv_reg, 4'(i)).z];
                na_reg[i] <= op_entry(conv_reg, 4'(i)).neg_a;
                nb_reg[i] <= op_entry(conv_reg, 4'(i)).neg_b;

                pa2_reg[i] <= pa_reg[i];
                fb_reg[i]  <= fmul(pb_reg[i], z_reg[i]);
                na2_reg[i] <= na_reg[i];
                nb2_reg[i] <= nb_reg[i];

                m_reg[i] <= sat_fix((na2_reg[i] ? -SAT_W'(pa2_reg[i]) : SAT_W'(pa2_reg[i]))
                                  + (nb2_reg[i] ? -SAT_W'(fb_reg[i]) : SAT_W'(fb_reg[i])));
            end
        end
    end

    // determinant: Sarrus products over two stages, sum in the output register
    always_comb begin
        det_sum = SAT_W'(dt_reg[0]) + SAT_W'(dt_reg[1]) + SAT_W'(dt_reg[2])
                - SAT_W'(dt_reg[3]) - SAT_W'(dt_reg[4]) - SAT_W'(dt_reg[5]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 6; k++) begin
                dp_reg[k] <= fmul(m_reg[DA[k]], m_reg[DB[k]]);
                dz_reg[k] <= m_reg[DC[k]];
                dt_reg[k] <= fmul(dp_reg[k], dz_reg[k]);
            end
            for (int i = 0; i < 9; i++) begin
                md_reg[i] <= m_reg[i];
                me_reg[i] <= md_reg[i];
                mo_reg[i] <= me_reg[i];
            end
            det_reg <= sat_fix(det_sum);
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < 9; i++) begin
            m_tdata[OUT_W*i +: OUT_W] = mo_reg[i];
        end
        m_tdata[OUT_W*9 +: OUT_W] = det_reg;
    end

    // checks
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no word waiting");

    a_pipe_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld_reg[LAT-2] |=> m_tvalid)
        else $error("word lost at the output stage");

    a_held_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved during a stall");

endmodule

FILE: verif/rotation_matrix_from_angles_test.sv
// Self-checking testbench for the rotation matrix from angles block.
module rotation_matrix_from_angles_test;
    import rmfa_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    // first_angle, second_angle, third_angle (16 bits each, from bit 0)
    logic [47:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // r11 .. r33, determinant (18 bits each), 4 zero bits on top
    logic [183:0] m_tdata;

    rotation_matrix_from_angles DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    localparam int PIPE_LAT  = 24;
    localparam int WDOG_MAX  = 20000;
    localparam int NUM_ENT   = 10;
    localparam int RAND_ITEMS = 320;

    typedef enum int { IDLE_SEND, IDLE_RECV, IDLE_NONE } idle_mode_e;

    typedef logic signed [63:0] wide_t;
    typedef logic [183:0] matrix_word_t;

    matrix_word_t matrix_q[$];
    logic         conv_model;
    idle_mode_e   idle_mode;
    int           err_count;
    int           wdog;
    bit           hold_recv;   // long receiver hold-off
    int           hold_len;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Predictor: sine / cosine by truncated Taylor series, fixed-point maths
    // ---------------------------------------------------------------------
    function automatic wide_t clamp_q2(input wide_t v);
        wide_t hi, lo;
        hi = (64'sd1 <<< (FRAC_BITS + 1)) - 1;
        lo = -(64'sd1 <<< (FRAC_BITS + 1));
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // rounded half up; arithmetic shift floors, which matches the biased form
    function automatic wide_t qmul(input wide_t a, input wide_t b);
        wide_t p;
        p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
        return clamp_q2(p >>> FRAC_BITS);
    endfunction

    function automatic wide_t qmul3(input wide_t a, input wide_t b, input wide_t c);
        return qmul(qmul(a, b), c);
    endfunction

    function automatic wide_t quarter_sine_q(input logic [63:0] rem);
        logic [63:0] one, x, x2, t, s;
        logic [127:0] xs;
        int div_tab [7];
        div_tab = '{210, 156, 110, 72, 42, 20, 6};
        one = 64'd1 << WORK_BITS;
        xs  = 128'(rem) * 128'(PI_Q60 >> 23);
        x   = 64'(xs >> (ANGLE_BITS + 6));
        x2  = (x * x) >> WORK_BITS;
        t   = one;
        for (int k = 0; k < 7; k++) begin
            t = one - ((x2 * t) >> WORK_BITS) / 64'(div_tab[k]);
        end
        s = (x * t) >> WORK_BITS;
        if (s > one) begin
            s = one;
        end
        return wide_t'((s + (64'd1 << (WORK_BITS - FRAC_BITS - 1))) >> (WORK_BITS - FRAC_BITS));
    endfunction

    task automatic angle_sin_cos(input logic [15:0] ang, output wide_t sn, output wide_t cs);
        logic [1:0]  quad;
        logic [63:0] rem;
        wide_t       sp, cp;
        quad = ang[15:14];
        rem  = 64'(ang[13:0]);
        sp   = quarter_sine_q(rem);
        cp   = quarter_sine_q((64'd1 << 14) - rem);
        case (quad)
            2'd0: begin sn = sp;  cs = cp;  end
            2'd1: begin sn = cp;  cs = -sp; end
            2'd2: begin sn = -sp; cs = -cp; end
            default: begin sn = -cp; cs = sp; end
        endcase
    endtask

    task automatic predict_matrix(input logic [47:0] angles, output matrix_word_t word);
        wide_t s1, c1, s2, c2, s3, c3, pos, neg, det;
        wide_t m [9];
        angle_sin_cos(angles[15:0],  s1, c1);
        angle_sin_cos(angles[31:16], s2, c2);
        angle_sin_cos(angles[47:32], s3, c3);
        if (conv_model == CONV_TILT) begin
            m[0] = clamp_q2(qmul(c2, c3) - qmul3(s1, s2, s3));
            m[1] = clamp_q2(qmul(c2, s3) + qmul3(s1, s2, c3));
            m[2] = clamp_q2(-qmul(c1, s2));
            m[3] = clamp_q2(-qmul(c1, s3));
            m[4] = qmul(c1, c3);
            m[5] = clamp_q2(s1);
            m[6] = clamp_q2(qmul(s2, c3) + qmul3(s1, c2, s3));
            m[7] = clamp_q2(qmul(s2, s3) - qmul3(s1, c2, c3));
            m[8] = qmul(c1, c2);
        end else begin
            m[0] = clamp_q2(qmul(c3, c1) - qmul3(c2, s3, s1));
            m[1] = clamp_q2(qmul(c3, s1) + qmul3(c2, s3, c1));
            m[2] = qmul(s3, s2);
            m[3] = clamp_q2(-qmul(s3, c1) - qmul3(c2, c3, s1));
            m[4] = clamp_q2(-qmul(s3, s1) + qmul3(c2, c3, c1));
            m[5] = qmul(c3, s2);
            m[6] = qmul(s2, s1);
            m[7] = clamp_q2(-qmul(s2, c1));
            m[8] = clamp_q2(c2);
        end
        pos = qmul3(m[0], m[4], m[8]) + qmul3(m[1], m[5], m[6]) + qmul3(m[2], m[3], m[7]);
        neg = qmul3(m[0], m[5], m[7]) + qmul3(m[1], m[3], m[8]) + qmul3(m[2], m[4], m[6]);
        det = clamp_q2(pos - neg);
        word = '0;
        for (int j = 0; j < 9; j++) begin
            word[j*OUT_W +: OUT_W] = m[j][OUT_W-1:0];
        end
        word[9*OUT_W +: OUT_W] = det[OUT_W-1:0];
    endtask

    // ---------------------------------------------------------------------
    // Result checker and receiver back-pressure
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        matrix_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (matrix_q.size() == 0) begin
                $error("result word with no prediction pending");
                err_count = err_count + 1;
            end else begin
                want = matrix_q.pop_front();
                for (int j = 0; j < NUM_ENT; j++) begin
                    if (m_tdata[j*OUT_W +: OUT_W] !== want[j*OUT_W +: OUT_W]) begin
                        if (j == 9) begin
                            $error("determinant: expected %0d, got %0d",
                                   $signed(want[j*OUT_W +: OUT_W]),
                                   $signed(m_tdata[j*OUT_W +: OUT_W]));
                        end else begin
                            $error("r%0d%0d: expected %0d, got %0d", j / 3 + 1, j % 3 + 1,
                                   $signed(want[j*OUT_W +: OUT_W]),
                                   $signed(m_tdata[j*OUT_W +: OUT_W]));
                        end
                        err_count = err_count + 1;
                    end
                end
                if (m_tdata[183:180] !== 4'b0) begin
                    $error("pad bits: expected 0, got %0h", m_tdata[183:180]);
                    err_count = err_count + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_recv) begin
            m_tready <= 1'b0;
        end else if (idle_mode == IDLE_RECV) begin
            m_tready <= ($urandom_range(99) >= 11);
        end else if (idle_mode == IDLE_SEND) begin
            m_tready <= ($urandom_range(99) >= 52);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // long hold-off, counted here so the sender keeps pushing meanwhile
    always @(posedge aclk) begin
        if (hold_len > 0) begin
            hold_recv <= 1'b1;
            hold_len  <= hold_len - 1;
        end else begin
            hold_recv <= 1'b0;
        end
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
        end
        if (wdog >= WDOG_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    // valid stays up between back-to-back words; it drops only in gaps
    task automatic send_angles(input logic [47:0] angles);
        matrix_word_t word;
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 11 : (idle_mode == IDLE_RECV) ? 52 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        predict_matrix(angles, word);
        s_tvalid <= 1'b1;
        s_tdata  <= angles;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        matrix_q = {matrix_q, word};
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (matrix_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    task automatic write_convention(input logic conv);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= conv;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid  <= 1'b0;
        conv_model = conv;
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        case ($urandom_range(5))
            0: a = 16'($urandom_range(3)) << 14;              // exact quadrant edge
            1: a = (16'($urandom_range(3)) << 14) + 16'($urandom_range(3)) - 16'd2;
            2: a = 16'($urandom_range(7)) << 13;              // eighth turns
            default: a = 16'($urandom);
        endcase
        return a;
    endfunction

    // quadrant edges, eighth turns, all-ones and alternating-bit words in both conventions
    task automatic test_directed();
        logic [15:0] edges [8];
        edges = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF, 16'h2000,
                  16'h0001};
        for (int c = 0; c < 2; c++) begin
            write_convention(c[0]);
            for (int i = 0; i < 8; i++) begin
                send_angles({edges[(i + 5) % 8], edges[(i + 3) % 8], edges[i]});
            end
            send_angles(48'hFFFF_FFFF_FFFF);
            send_angles(48'h5555_AAAA_5555);
        end
    endtask

    task automatic test_random(input int count, input idle_mode_e mode);
        idle_mode = mode;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                write_convention(1'($urandom_range(1)));
                idle_mode = mode;
            end
            send_angles({pick_angle(), pick_angle(), pick_angle()});
        end
    endtask

    // receiver stalls for long while words keep coming: the pipeline backs up
    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        hold_len  = 200;
        for (int i = 0; i < 60; i++) begin
            send_angles({16'($urandom), 16'($urandom), 16'($urandom)});
        end
        wait_drained();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        hold_recv = 1'b0;
        hold_len  = 0;
        wdog      = 0;
        err_count = 0;
        conv_model = CONV_TILT;
        idle_mode = IDLE_SEND;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value of the convention first, no write yet
        send_angles({16'h1234, 16'h4321, 16'h0F0F});
        test_directed();
        test_random(RAND_ITEMS / 3, IDLE_SEND);
        test_random(RAND_ITEMS / 3, IDLE_RECV);
        test_random(RAND_ITEMS / 3, IDLE_NONE);
        test_backpressure();

        wait_drained();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
